// ----- rtl/sfcr_pkg.sv -----
// Package for the sync-framed checksum receiver.
// Frame layout constants and the result record type; no dependencies.
`timescale 1ns / 1ps

package sfcr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned SUM_W    = 11;
  localparam int unsigned PAYLOAD_LEN = 5;
  localparam int unsigned IDX_W    = 3;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFF;
  localparam logic [BYTE_W-1:0] ALT_CHECK    = 8'hFE;
  localparam logic [BYTE_W-1:0] CENTER_VALUE = 8'h80;
  localparam logic [SUM_W-1:0]  ALT_SUM      = 11'h0FF;
  localparam int unsigned       LOCK_BIT     = 1;

  localparam logic [POS_W-1:0] HEADER_POS    = 3'd0;
  localparam logic [POS_W-1:0] FIRST_PAYLOAD = 3'd1;
  localparam logic [POS_W-1:0] LAST_PAYLOAD  = 3'd5;
  localparam logic [POS_W-1:0] CHECK_POS     = 3'd6;

  localparam logic [IDX_W-1:0] EXT_IDX   = 3'd0;
  localparam logic [IDX_W-1:0] CHIN_IDX  = 3'd1;
  localparam logic [IDX_W-1:0] TILT_IDX  = 3'd2;
  localparam logic [IDX_W-1:0] PITCH_IDX = 3'd3;
  localparam logic [IDX_W-1:0] YAW_IDX   = 3'd4;

  typedef struct packed {
    logic              frame_done;
    logic              check_ok;
    logic [BYTE_W-1:0] ext_value;
    logic [BYTE_W-1:0] chin_value;
    logic [BYTE_W-1:0] tilt_value;
    logic [BYTE_W-1:0] pitch_value;
    logic [BYTE_W-1:0] yaw_value;
  } result_t;

endpackage

// ----- rtl/sfcr_channels.sv -----
// Valid/ready channel interfaces for the receiver: byte input and result output.
// Depends on sfcr_pkg for field widths.
`timescale 1ns / 1ps

interface sfcr_byte_if;
  import sfcr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcr_result_if;
  import sfcr_pkg::*;
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic              check_ok;
  logic [BYTE_W-1:0] ext_value;
  logic [BYTE_W-1:0] chin_value;
  logic [BYTE_W-1:0] tilt_value;
  logic [BYTE_W-1:0] pitch_value;
  logic [BYTE_W-1:0] yaw_value;

  modport source (output valid, output frame_done, output check_ok, output ext_value,
                  output chin_value, output tilt_value, output pitch_value,
                  output yaw_value, input ready);
  modport sink   (input valid, input frame_done, input check_ok, input ext_value,
                  input chin_value, input tilt_value, input pitch_value,
                  input yaw_value, output ready);
endinterface

// ----- rtl/sfcr_frame_core.sv -----
// Frame tracker: position, running sum, payload bytes and latched control values.
// Updates on each accepted byte and presents the post-update result. Uses sfcr_pkg.
`timescale 1ns / 1ps

module sfcr_frame_core
  import sfcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output result_t           result_next
);

  logic [POS_W-1:0]  position, position_next;
  logic [SUM_W-1:0]  running_sum, running_sum_next;
  logic [BYTE_W-1:0] payload [PAYLOAD_LEN];
  logic [BYTE_W-1:0] ext_latched, ext_latched_next;
  logic [BYTE_W-1:0] chin_latched, chin_latched_next;
  logic [BYTE_W-1:0] tilt_latched, tilt_latched_next;
  logic [BYTE_W-1:0] pitch_latched, pitch_latched_next;
  logic [BYTE_W-1:0] yaw_latched, yaw_latched_next;
  logic              check_flag, check_flag_next;

  logic [POS_W-1:0]  pos_eff;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_en;
  logic              done;
  logic              pass;

  always_comb begin
    pos_eff            = (rx_byte == SYNC_BYTE) ? HEADER_POS : position;
    wr_idx             = IDX_W'(pos_eff - FIRST_PAYLOAD);
    wr_en              = 1'b0;
    done               = 1'b0;
    pass               = (running_sum[BYTE_W-1:0] == rx_byte) ||
                         (running_sum == ALT_SUM && rx_byte == ALT_CHECK);
    position_next      = position;
    running_sum_next   = running_sum;
    ext_latched_next   = ext_latched;
    chin_latched_next  = chin_latched;
    tilt_latched_next  = tilt_latched;
    pitch_latched_next = pitch_latched;
    yaw_latched_next   = yaw_latched;
    check_flag_next    = check_flag;

    if (pos_eff inside {[FIRST_PAYLOAD:LAST_PAYLOAD]}) begin
      wr_en            = 1'b1;
      running_sum_next = running_sum + SUM_W'(rx_byte);
      position_next    = pos_eff + POS_W'(1);
    end else if (pos_eff == CHECK_POS) begin
      done            = 1'b1;
      check_flag_next = pass;
      if (pass) begin
        ext_latched_next = payload[EXT_IDX];
        if (!payload[EXT_IDX][LOCK_BIT]) begin
          chin_latched_next  = payload[CHIN_IDX];
          tilt_latched_next  = payload[TILT_IDX];
          pitch_latched_next = payload[PITCH_IDX];
          yaw_latched_next   = payload[YAW_IDX];
        end
      end
      position_next = HEADER_POS;
    end else begin
      running_sum_next = '0;
      position_next    = FIRST_PAYLOAD;
    end

    result_next.frame_done  = done;
    result_next.check_ok    = check_flag_next;
    result_next.ext_value   = ext_latched_next;
    result_next.chin_value  = chin_latched_next;
    result_next.tilt_value  = tilt_latched_next;
    result_next.pitch_value = pitch_latched_next;
    result_next.yaw_value   = yaw_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= HEADER_POS;
      running_sum   <= '0;
      ext_latched   <= '0;
      chin_latched  <= '0;
      tilt_latched  <= '0;
      pitch_latched <= CENTER_VALUE;
      yaw_latched   <= CENTER_VALUE;
      check_flag    <= 1'b0;
    end else if (step) begin
      position      <= position_next;
      running_sum   <= running_sum_next;
      ext_latched   <= ext_latched_next;
      chin_latched  <= chin_latched_next;
      tilt_latched  <= tilt_latched_next;
      pitch_latched <= pitch_latched_next;
      yaw_latched   <= yaw_latched_next;
      check_flag    <= check_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      payload[wr_idx] <= rx_byte;
    end
  end

endmodule

// ----- rtl/sync_frame_checksum_receiver.sv -----
// Top level of the sync-framed checksum receiver.
// Depends on sfcr_pkg, sfcr_channels and sfcr_frame_core.
//
// Usage:
//   frame_in carries one received serial byte per transaction (rx_byte).
//   frame_out carries one result per input byte: frame_done marks the
//   checksum byte of a frame, check_ok is the outcome of the latest
//   checksum test, and the five value fields are the latched extended and
//   control bytes after that byte has been taken.
//   A byte of 0xFF restarts a frame at any point. A frame is a header, five
//   payload bytes and a checksum byte.
//   The result appears on frame_out in the cycle after the input
//   transaction. Throughput: one byte per cycle while frame_out takes each
//   result, limited only by the single output register.
//   Stall: while frame_out is valid and not taken, frame_in.ready is low;
//   taking the waiting result lets a new byte in on the same cycle.
//   Reset: frame position and sum clear, check_ok is 0, the extended, chin
//   and tilt values are 0x00, pitch and yaw are 0x80; no result is pending.
`timescale 1ns / 1ps

module sync_frame_checksum_receiver
  import sfcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sfcr_byte_if.sink     frame_in,
  sfcr_result_if.source frame_out
);

  logic    out_valid;
  result_t out_data;
  result_t result_next;
  logic    step;

  assign frame_in.ready = !out_valid || frame_out.ready;
  assign step           = frame_in.valid && frame_in.ready;

  sfcr_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (frame_in.rx_byte),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_in.ready) begin
      out_valid <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result_next;
    end
  end

  assign frame_out.valid       = out_valid;
  assign frame_out.frame_done  = out_data.frame_done;
  assign frame_out.check_ok    = out_data.check_ok;
  assign frame_out.ext_value   = out_data.ext_value;
  assign frame_out.chin_value  = out_data.chin_value;
  assign frame_out.tilt_value  = out_data.tilt_value;
  assign frame_out.pitch_value = out_data.pitch_value;
  assign frame_out.yaw_value   = out_data.yaw_value;

endmodule

// ----- verif/sfcr_result_checker.sv -----
// Result checker for the sync-framed checksum receiver: watches both channels,
// predicts each result from the accepted bytes and compares field by field.
// Depends on sfcr_pkg and the channel interfaces in sfcr_channels.
`timescale 1ns / 1ps

module sfcr_result_checker
  import sfcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  sfcr_byte_if   frame_in,
  sfcr_result_if frame_out,
  output int     fail_count,
  output int     pending,
  output int     frames_judged,
  output int     frames_passed
);

  localparam int REPORT_LIMIT = 30;

  logic [POS_W-1:0]  byte_slot;
  logic [SUM_W-1:0]  byte_total;
  logic [BYTE_W-1:0] body_bytes [PAYLOAD_LEN];
  result_t           shown;
  result_t           awaited_results [$];
  int                mismatches;
  int                judged;
  int                passed;
  int                reports_left = REPORT_LIMIT;

  function automatic result_t take_rx_byte(input logic [BYTE_W-1:0] b);
    logic [POS_W-1:0] slot;
    logic             good;
    slot = (b == SYNC_BYTE) ? HEADER_POS : byte_slot;
    shown.frame_done = 1'b0;
    if (slot >= FIRST_PAYLOAD && slot <= LAST_PAYLOAD) begin
      body_bytes[slot - FIRST_PAYLOAD] = b;
      byte_total = byte_total + b;
      byte_slot = slot + 1'b1;
    end else if (slot == CHECK_POS) begin
      good = (byte_total[BYTE_W-1:0] == b) || (byte_total == ALT_SUM && b == ALT_CHECK);
      shown.frame_done = 1'b1;
      shown.check_ok = good;
      judged++;
      if (good) begin
        passed++;
        shown.ext_value = body_bytes[EXT_IDX];
        if (!shown.ext_value[LOCK_BIT]) begin
          shown.chin_value  = body_bytes[CHIN_IDX];
          shown.tilt_value  = body_bytes[TILT_IDX];
          shown.pitch_value = body_bytes[PITCH_IDX];
          shown.yaw_value   = body_bytes[YAW_IDX];
        end
      end
      byte_slot = HEADER_POS;
    end else begin
      byte_total = '0;
      byte_slot = FIRST_PAYLOAD;
    end
    return shown;
  endfunction

  function automatic void check_field(input string what, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (reports_left > 0) begin
        reports_left--;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      byte_slot = HEADER_POS;
      byte_total = '0;
      foreach (body_bytes[i]) body_bytes[i] = '0;
      shown = '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, CENTER_VALUE, CENTER_VALUE};
      awaited_results.delete();
    end else begin
      if (frame_in.valid && frame_in.ready)
        awaited_results.push_back(take_rx_byte(frame_in.rx_byte));
      if (frame_out.valid && frame_out.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (reports_left > 0) begin
            reports_left--;
            $display("%0t: unexpected result, expected none, actual ext %h check_ok %b",
                     $time, frame_out.ext_value, frame_out.check_ok);
          end
        end else begin
          want = awaited_results.pop_front();
          check_field("frame_done", BYTE_W'(want.frame_done), BYTE_W'(frame_out.frame_done));
          check_field("check_ok", BYTE_W'(want.check_ok), BYTE_W'(frame_out.check_ok));
          check_field("ext_value", want.ext_value, frame_out.ext_value);
          check_field("chin_value", want.chin_value, frame_out.chin_value);
          check_field("tilt_value", want.tilt_value, frame_out.tilt_value);
          check_field("pitch_value", want.pitch_value, frame_out.pitch_value);
          check_field("yaw_value", want.yaw_value, frame_out.yaw_value);
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= awaited_results.size();
    frames_judged <= judged;
    frames_passed <= passed;
  end

endmodule

// ----- verif/tb_sync_frame_checksum_receiver.sv -----
// Testbench top for the sync-framed checksum receiver: clock, reset, byte stimulus
// and result back-pressure; the verdict comes from sfcr_result_checker.
// Depends on sfcr_pkg, sfcr_channels, the receiver RTL and the checker.
`timescale 1ns / 1ps

module tb_sync_frame_checksum_receiver;
  import sfcr_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int PHASE_BYTES   = 375;
  localparam int LONG_HOLD     = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BODY_MAX      = int'(ALT_CHECK);
  localparam int BODY_LEN      = PAYLOAD_LEN;

  typedef enum logic [1:0] {SINK_FREE, SINK_LIGHT, SINK_PERIODIC, SINK_HEAVY} sink_mode_e;
  typedef enum logic [2:0] {SUM_RIGHT, SUM_WRONG, SUM_ALT, SUM_NEAR_MISS, SUM_SYNC} check_kind_e;
  typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] body_t;

  logic       clk = 1'b0;
  logic       rst;
  sink_mode_e sink_mode;
  logic       hold_req;
  logic       hold_seen;
  int         hold_left;
  logic [3:0] sink_tick = '0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         burst_left = 1;
  bit         gappy;
  bit         aligned;
  int         fail_count;
  int         pending;
  int         frames_judged;
  int         frames_passed;

  sfcr_byte_if   byte_ch ();
  sfcr_result_if result_ch ();

  sync_frame_checksum_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (byte_ch),
    .frame_out (result_ch)
  );

  sfcr_result_checker result_checker (
    .clk           (clk),
    .rst           (rst),
    .frame_in      (byte_ch),
    .frame_out     (result_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .frames_judged (frames_judged),
    .frames_passed (frames_passed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sync_frame_checksum_receiver] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    sink_tick <= sink_tick + 1'b1;
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_FREE:     result_ch.ready <= 1'b1;
        SINK_LIGHT:    result_ch.ready <= ($urandom_range(3, 0) != 0);
        SINK_PERIODIC: result_ch.ready <= (sink_tick >= 4'd5);
        default:       result_ch.ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  task automatic idle_for(input int cycles);
    byte_ch.valid <= 1'b0;
    byte_ch.rx_byte <= BYTE_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    if (gappy) begin
      burst_left--;
      if (burst_left <= 0) begin
        idle_for(($urandom_range(9, 0) == 0) ? $urandom_range(24, 12) : $urandom_range(4, 1));
        burst_left = $urandom_range(16, 1);
      end
    end
  endtask

  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic body_t spread_total(input int target);
    body_t body;
    int    lo;
    int    hi;
    int    left;
    left = target;
    for (int i = 0; i < BODY_LEN; i++) begin
      lo = left - (BODY_LEN - 1 - i) * BODY_MAX;
      if (lo < 0) lo = 0;
      hi = (left < BODY_MAX) ? left : BODY_MAX;
      body[i] = BYTE_W'($urandom_range(hi, lo));
      left -= body[i];
    end
    return body;
  endfunction

  task automatic send_frame(input logic [BYTE_W-1:0] header, input body_t body,
                            input check_kind_e kind);
    logic [SUM_W-1:0]  total;
    logic [BYTE_W-1:0] check;
    total = '0;
    for (int i = 0; i < BODY_LEN; i++) total += body[i];
    case (kind)
      SUM_RIGHT: check = (total[BYTE_W-1:0] == SYNC_BYTE) ? ALT_CHECK : total[BYTE_W-1:0];
      SUM_WRONG: begin
        do check = BYTE_W'($urandom_range(BODY_MAX, 0));
        while (check == total[BYTE_W-1:0] || (total == ALT_SUM && check == ALT_CHECK));
      end
      SUM_SYNC:  check = SYNC_BYTE;
      default:   check = ALT_CHECK;
    endcase
    send_byte(header);
    for (int i = 0; i < BODY_LEN; i++) send_byte(body[i]);
    send_byte(check);
    aligned = (check != SYNC_BYTE);
  endtask

  task automatic random_unit();
    int               pick;
    int               count;
    body_t            body;
    check_kind_e      kind;
    logic [BYTE_W-1:0] header;
    pick = $urandom_range(99, 0);
    if (pick < 72) begin
      count = $urandom_range(99, 0);
      if (count < 50)      kind = SUM_RIGHT;
      else if (count < 65) kind = SUM_WRONG;
      else if (count < 77) kind = SUM_ALT;
      else if (count < 87) kind = SUM_NEAR_MISS;
      else                 kind = SUM_SYNC;
      if (kind == SUM_ALT)
        body = spread_total(int'(ALT_SUM));
      else if (kind == SUM_NEAR_MISS)
        body = spread_total(256 * $urandom_range(3, 1) + 255);
      else
        foreach (body[i]) body[i] = BYTE_W'($urandom_range(BODY_MAX, 0));
      header = (aligned && $urandom_range(1, 0)) ? BYTE_W'($urandom_range(BODY_MAX, 0))
                                                 : SYNC_BYTE;
      send_frame(header, body, kind);
    end else if (pick < 86) begin
      send_byte(SYNC_BYTE);
      count = $urandom_range(4, 0);
      repeat (count) send_byte(BYTE_W'($urandom_range(BODY_MAX, 0)));
      aligned = 1'b0;
    end else begin
      count = $urandom_range(8, 1);
      repeat (count) send_byte(BYTE_W'($urandom));
      aligned = 1'b0;
    end
  endtask

  initial begin : stimulus
    int phase_start;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    sink_mode = SINK_LIGHT;
    hold_req = 1'b0;
    gappy = 1'b1;
    aligned = 1'b1;
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // locked extended byte, plain pass with the sum above 0xFF
    send_frame(SYNC_BYTE, {8'h7E, 8'h7F, 8'h01, 8'hFE, 8'h02}, SUM_RIGHT);
    // non-sync header, sum of exactly 0xFF carried as 0xFE
    send_frame(8'h00, {8'h00, 8'h00, 8'h00, 8'hFE, 8'h01}, SUM_ALT);
    // sync inside a frame, then a failed checksum
    send_byte(8'h5A);
    send_byte(8'h80);
    send_byte(8'h11);
    send_frame(SYNC_BYTE, {8'h44, 8'h33, 8'h22, 8'h11, 8'h80}, SUM_WRONG);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      sink_mode <= sink_mode_e'(phase);
      gappy = (phase >= 2);
      if (sink_mode_e'(phase) == SINK_LIGHT) hold_req <= ~hold_req;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) random_unit();
      drain_results();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; %0d checksum bytes judged, %0d passed, under four sink modes",
             bytes_sent, frames_judged, frames_passed);
    $display("and one long hold-off with the sender still offering.");
    if (fail_count == 0 && pending == 0) begin
      $display("[sync_frame_checksum_receiver] OK");
    end else begin
      $display("[sync_frame_checksum_receiver] ERROR");
    end
    $finish;
  end

endmodule
